### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### hdl/pid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

  // field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned LIM_W    = 15;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned APB_W    = 32;

  // datapath widths
  localparam int unsigned ERR_W    = IN_W + 1;
  localparam int unsigned DERR_W   = ERR_W + 1;
  localparam int unsigned INT_W    = 48;
  localparam int unsigned HALF_W   = INT_W / 2;
  localparam int unsigned MA_W     = GAIN_W + 1;
  localparam int unsigned MB_W     = HALF_W + 1;
  localparam int unsigned PROD_W   = MA_W + MB_W;
  localparam int unsigned EDT_W    = ERR_W + DT_W;
  localparam int unsigned P_W      = GAIN_W + ERR_W;
  localparam int unsigned DPROD_W  = GAIN_W + DERR_W;
  localparam int unsigned DNUM_W   = DPROD_W + 10;
  localparam int unsigned DMAG_W   = DNUM_W - 1;
  localparam int unsigned IPART_W  = GAIN_W + HALF_W;
  localparam int unsigned ITERM_W  = 61;
  localparam int unsigned SUM_W    = 63;
  localparam int unsigned LOSUM_W  = LIM_W + FRAC_W + 1;

  // iterative divider
  localparam int unsigned DIV_W     = IPART_W + HALF_W;
  localparam int unsigned DIVR_W    = DT_W;
  localparam int unsigned DIV_RADIX = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DIVR_W-1:0]  I_DIVISOR   = DIVR_W'(1000);
  localparam logic [DIV_W-1:0]   ITERM_LIM   = DIV_W'(1) << (ITERM_W - 1);
  localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(100);

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_E_DT,
    MUL_P,
    MUL_I_HI,
    MUL_I_LO,
    MUL_D
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     int_upd;
    logic     sum_init;
    logic     ihi_ld;
    logic     dnum_ld;
    logic     div_start;
    logic     div_sel_d;
    logic     add_i;
    logic     add_d;
    logic     out_ld;
  } pid_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic dt_zero;
    logic out_free;
  } pid_sts_t;

endpackage

`default_nettype wire

### hdl/pid_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pid_pkg::DIV_W-1:0]   dividend_i,
  input  logic [pid_pkg::DIVR_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [pid_pkg::DIV_W-1:0]   quotient_o
);
  import pid_pkg::*;

  logic                  busy_q, done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIV_W-1:0]      sh_q, sh_d;
  logic [DIVR_W-1:0]     rem_q, rem_d;
  logic [DIVR_W-1:0]     dvs_q;

  // restoring division, several quotient bits per cycle on a narrow remainder
  always_comb begin
    logic [DIVR_W:0] trial;
    trial = '0;
    sh_d  = sh_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial = {rem_d, sh_d[DIV_W-1]};
      sh_d  = {sh_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        sh_d[0]  = 1'b1;
      end
      rem_d = trial[DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

`default_nettype wire

### hdl/pid_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pid_pkg::pid_cmd_t                  cmd_i,
  output pid_pkg::pid_sts_t                  sts_o,
  input  logic signed [pid_pkg::IN_W-1:0]    setpoint_i,
  input  logic signed [pid_pkg::IN_W-1:0]    measured_i,
  input  logic        [pid_pkg::DT_W-1:0]    dt_ms_i,
  input  logic signed [pid_pkg::GAIN_W-1:0]  gain_p_i,
  input  logic signed [pid_pkg::GAIN_W-1:0]  gain_i_i,
  input  logic signed [pid_pkg::GAIN_W-1:0]  gain_d_i,
  input  logic        [pid_pkg::LIM_W-1:0]   output_limit_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [pid_pkg::OUT_W-1:0]   drive_o,
  output logic                               clamped_o
);
  import pid_pkg::*;

  logic signed [ERR_W-1:0]   err_q, prev_q;
  logic        [DT_W-1:0]    dt_q;
  logic signed [INT_W-1:0]   integ_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic        [IPART_W-1:0] ihi_q;
  logic signed [DNUM_W-1:0]  dnum_q, dnum_d;
  logic                      dneg_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      out_vld_q, clamped_q;
  logic signed [OUT_W-1:0]   drive_q;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [DERR_W-1:0]  derr;
  logic        [GAIN_W-1:0]  gi_mag;
  logic        [INT_W-1:0]   am;
  logic signed [INT_W:0]     isum;
  logic signed [INT_W-1:0]   integ_d;
  logic signed [DPROD_W-1:0] dprod;
  logic        [DIV_W-1:0]   div_dvd, quot;
  logic        [DIVR_W-1:0]  div_dvs;
  logic                      div_busy, div_done;
  logic                      ineg;
  logic        [ITERM_W-1:0] i_mag;
  logic        [DMAG_W-1:0]  d_mag;
  logic signed [SUM_W-1:0]   lim_pos, lim_neg;
  logic signed [LOSUM_W-1:0] s_lo, s_rnd;
  logic signed [OUT_W-1:0]   drive_d;
  logic                      clamped_d;

  assign derr   = DERR_W'(err_q) - DERR_W'(prev_q);
  assign gi_mag = gain_i_i[GAIN_W-1] ? GAIN_W'(-gain_i_i) : GAIN_W'(gain_i_i);
  assign am     = integ_q[INT_W-1] ? INT_W'(-integ_q) : INT_W'(integ_q);
  assign ineg   = gain_i_i[GAIN_W-1] ^ integ_q[INT_W-1];

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_E_DT: begin
        mul_a = MA_W'(err_q);
        mul_b = $signed(MB_W'(dt_q));
      end
      MUL_P: begin
        mul_a = MA_W'(gain_p_i);
        mul_b = MB_W'(err_q);
      end
      MUL_I_HI: begin
        mul_a = $signed(MA_W'(gi_mag));
        mul_b = $signed(MB_W'(am[INT_W-1:HALF_W]));
      end
      MUL_I_LO: begin
        mul_a = $signed(MA_W'(gi_mag));
        mul_b = $signed(MB_W'(am[HALF_W-1:0]));
      end
      MUL_D: begin
        mul_a = MA_W'(gain_d_i);
        mul_b = MB_W'(derr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // saturating integral
  assign isum = (INT_W + 1)'(integ_q) + (INT_W + 1)'($signed(prod_q[EDT_W-1:0]));
  always_comb begin
    if (isum[INT_W] != isum[INT_W-1]) begin
      integ_d = isum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
    end else begin
      integ_d = isum[INT_W-1:0];
    end
  end

  // derivative numerator times 1000
  assign dprod  = $signed(prod_q[DPROD_W-1:0]);
  assign dnum_d = (DNUM_W'(dprod) <<< 10) - (DNUM_W'(dprod) <<< 4) - (DNUM_W'(dprod) <<< 3);

  always_comb begin
    if (cmd_i.div_sel_d) begin
      div_dvd = DIV_W'(dnum_q[DNUM_W-1] ? DMAG_W'(-dnum_q) : DMAG_W'(dnum_q));
      div_dvs = dt_q;
    end else begin
      div_dvd = {ihi_q, HALF_W'(0)} + DIV_W'(prod_q[IPART_W-1:0]);
      div_dvs = I_DIVISOR;
    end
  end

  pid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign i_mag = (quot > ITERM_LIM) ? ITERM_LIM[ITERM_W-1:0] : quot[ITERM_W-1:0];
  assign d_mag = quot[DMAG_W-1:0];

  // output clamp
  assign lim_pos = $signed(SUM_W'({output_limit_i, FRAC_W'(0)}));
  assign lim_neg = -lim_pos;
  assign s_lo    = sum_q[LOSUM_W-1:0];
  assign s_rnd   = s_lo + (s_lo[LOSUM_W-1] ? $signed(LOSUM_W'({FRAC_W{1'b1}})) : '0);

  always_comb begin
    if (sum_q > lim_pos) begin
      drive_d   = $signed(OUT_W'(output_limit_i));
      clamped_d = 1'b1;
    end else if (sum_q < lim_neg) begin
      drive_d   = -$signed(OUT_W'(output_limit_i));
      clamped_d = 1'b1;
    end else begin
      drive_d   = s_rnd[LOSUM_W-1:FRAC_W];
      clamped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      prev_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        integ_q <= '0;
        prev_q  <= '0;
      end else if (cmd_i.int_upd) begin
        integ_q <= integ_d;
      end
      if (cmd_i.out_ld) begin
        prev_q    <= err_q;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= ERR_W'(setpoint_i) - ERR_W'(measured_i);
      dt_q  <= dt_ms_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ihi_ld) begin
      ihi_q <= prod_q[IPART_W-1:0];
    end
    if (cmd_i.dnum_ld) begin
      dnum_q <= dnum_d;
    end
    if (cmd_i.div_start && cmd_i.div_sel_d) begin
      dneg_q <= dnum_q[DNUM_W-1];
    end
    if (cmd_i.sum_init) begin
      sum_q <= SUM_W'($signed(prod_q[P_W-1:0]));
    end else if (cmd_i.add_i) begin
      sum_q <= ineg ? sum_q - $signed(SUM_W'(i_mag)) : sum_q + $signed(SUM_W'(i_mag));
    end else if (cmd_i.add_d) begin
      sum_q <= dneg_q ? sum_q - $signed(SUM_W'(d_mag)) : sum_q + $signed(SUM_W'(d_mag));
    end
    if (cmd_i.out_ld) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule

`default_nettype wire

### hdl/pid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_clear_i,
  output logic              in_ready_o,
  input  pid_pkg::pid_sts_t sts_i,
  output pid_pkg::pid_cmd_t cmd_o
);
  import pid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_UPD_INT,
    ST_ADD_P,
    ST_HOLD_HI,
    ST_DIV_I,
    ST_WAIT_I,
    ST_DIV_D,
    ST_WAIT_D,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_clear_i) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_MUL_EDT;
          end
        end
      end
      ST_MUL_EDT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_E_DT;
        state_d       = ST_UPD_INT;
      end
      ST_UPD_INT: begin
        cmd_o.int_upd = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P;
        state_d       = ST_ADD_P;
      end
      ST_ADD_P: begin
        cmd_o.sum_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_I_HI;
        state_d        = ST_HOLD_HI;
      end
      ST_HOLD_HI: begin
        cmd_o.ihi_ld  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_I_LO;
        state_d       = ST_DIV_I;
      end
      ST_DIV_I: begin
        cmd_o.div_start = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_D;
        state_d         = ST_WAIT_I;
      end
      ST_WAIT_I: begin
        cmd_o.dnum_ld = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.add_i = 1'b1;
          state_d     = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (sts_i.dt_zero) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_d = 1'b1;
          state_d         = ST_WAIT_D;
        end
      end
      ST_WAIT_D: begin
        cmd_o.div_sel_d = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.add_d = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pid_step_with_output_clamp.sv
// PID step with output clamp. A step beat (tuser 0) uses the shared 33x25 multiplier,
// then one pass of the iterative divider for the integral term (divide by 1000) and one
// for the derivative term (divide by dt_ms, skipped when dt_ms is zero), each at 4 quotient
// bits per cycle over an 80-bit dividend; no new beat is taken until the step is done. A
// clear beat (tuser 1) yields no result. The result sits in an output register, so the
// next beat is taken while it waits. The user must write registers over APB only while
// the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pid_step_with_output_clamp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // setpoint, measured, dt_ms
  input  logic                        s_axis_tuser,  // opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // drive
  output logic                        m_axis_tuser,  // clamped
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pid_pkg::ADDR_W-1:0]  paddr,
  input  logic [pid_pkg::APB_W-1:0]   pwdata,
  output logic [pid_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);
  import pid_pkg::*;

  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic        [LIM_W-1:0]  limit_q;
  logic                     apb_wr;
  reg_idx_e                 reg_idx;
  pid_cmd_t                 cmd;
  pid_sts_t                 sts;
  logic signed [OUT_W-1:0]  drive;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_GAIN_P: gain_p_q <= $signed(pwdata[GAIN_W-1:0]);
        REG_GAIN_I: gain_i_q <= $signed(pwdata[GAIN_W-1:0]);
        REG_GAIN_D: gain_d_q <= $signed(pwdata[GAIN_W-1:0]);
        REG_LIMIT:  limit_q  <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P: prdata = APB_W'(gain_p_q);
      REG_GAIN_I: prdata = APB_W'(gain_i_q);
      REG_GAIN_D: prdata = APB_W'(gain_d_q);
      REG_LIMIT:  prdata = APB_W'(limit_q);
    endcase
  end

  pid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pid_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .setpoint_i     ($signed(s_axis_tdata[15:0])),
    .measured_i     ($signed(s_axis_tdata[31:16])),
    .dt_ms_i        (s_axis_tdata[47:32]),
    .gain_p_i       (gain_p_q),
    .gain_i_i       (gain_i_q),
    .gain_d_i       (gain_d_q),
    .output_limit_i (limit_q),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .drive_o        (drive),
    .clamped_o      (m_axis_tuser)
  );

  assign m_axis_tdata = drive;

  `ASSERT_NEVER(a_div_restart, clk_i, rst_ni, cmd.div_start && sts.div_busy, "divider restarted while busy")
  `ASSERT_PROP(a_out_no_overwrite, clk_i, rst_ni, cmd.out_ld |-> (!m_axis_tvalid || m_axis_tready), "pending result overwritten")
  `ASSERT_PROP(a_step_blocks_input, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready, "input taken during a step")
  `ASSERT_PROP(a_div_start_busy, clk_i, rst_ni, cmd.div_start |=> sts.div_busy, "divider did not start")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

import pid_pkg::*;

typedef enum logic {
  OP_STEP  = 1'b0,
  OP_CLEAR = 1'b1
} pid_op_e;

typedef enum logic [1:0] {
  RX_OPEN,
  RX_COIN,
  RX_SPARSE,
  RX_HOLD
} rx_mode_e;

typedef struct packed {
  logic               clamped;
  logic signed [15:0] drive;
} drive_beat_t;

localparam longint      INTEG_HI = (longint'(1) <<< 47) - 1;
localparam longint      INTEG_LO = -(longint'(1) <<< 47);
localparam logic [95:0] IMAG_CAP = 96'd1 << 60;

class drive_scoreboard;
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [14:0]        output_limit;
  longint             integral;
  longint             prev_err;
  drive_beat_t        drive_expected[$];
  int unsigned        mismatches;

  function new();
    gain_p       = '0;
    gain_i       = '0;
    gain_d       = '0;
    output_limit = 15'd100;
    integral     = 0;
    prev_err     = 0;
    mismatches   = 0;
  endfunction

  function void write_reg(reg_idx_e idx, logic [31:0] value);
    case (idx)
      REG_GAIN_P: gain_p = value;
      REG_GAIN_I: gain_i = value;
      REG_GAIN_D: gain_d = value;
      REG_LIMIT:  output_limit = value[14:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return drive_expected.size();
  endfunction

  function void predict_drive(pid_op_e op, logic signed [15:0] sp, logic signed [15:0] ms,
                              logic [15:0] dt);
    longint      err;
    longint      acc;
    longint      ki;
    longint      i_term;
    longint      d_term;
    longint      sum;
    longint      lim;
    logic [95:0] prod;
    logic [95:0] i_mag;
    drive_beat_t beat;
    if (op == OP_CLEAR) begin
      integral = 0;
      prev_err = 0;
      return;
    end
    err = longint'(sp) - longint'(ms);
    acc = integral + err * longint'(dt);
    if (acc > INTEG_HI) acc = INTEG_HI;
    if (acc < INTEG_LO) acc = INTEG_LO;
    integral = acc;

    // integral term: magnitude truncated toward zero, capped at 2^60
    ki    = longint'(gain_i);
    prod  = 96'(ki < 0 ? -ki : ki) * 96'(acc < 0 ? -acc : acc);
    i_mag = prod / 96'd1000;
    if (i_mag > IMAG_CAP) i_mag = IMAG_CAP;
    i_term = longint'(i_mag[63:0]);
    if ((ki < 0) != (acc < 0)) i_term = -i_term;

    d_term = 0;
    if (dt != 0) d_term = (longint'(gain_d) * (err - prev_err) * 1000) / longint'(dt);

    sum = longint'(gain_p) * err + i_term + d_term;
    lim = longint'(output_limit) * 65536;
    if (sum > lim) begin
      beat.drive   = 16'(longint'(output_limit));
      beat.clamped = 1'b1;
    end else if (sum < -lim) begin
      beat.drive   = 16'(-longint'(output_limit));
      beat.clamped = 1'b1;
    end else begin
      beat.drive   = 16'(sum / 65536);
      beat.clamped = 1'b0;
    end
    prev_err = err;
    drive_expected.push_back(beat);
  endfunction

  function void report_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= 100) $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  function void check_drive(logic signed [15:0] drive, logic clamped);
    drive_beat_t want;
    if (drive_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 100) $error("drive: expected no beat, got %0d", drive);
      return;
    end
    want = drive_expected.pop_front();
    if (drive !== want.drive) report_mismatch("drive", want.drive, drive);
    if (clamped !== want.clamped) report_mismatch("clamped", want.clamped, clamped);
  endfunction
endclass

module testbench;
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata  = '0;    // setpoint, measured, dt_ms
  logic              s_axis_tuser  = 1'b0;  // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;          // drive
  logic              m_axis_tuser;          // clamped
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [APB_W-1:0]  pwdata        = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  drive_scoreboard board;
  int              burst_left  = 0;
  bit              sender_gaps = 1'b1;
  bit              rx_free     = 1'b0;
  rx_mode_e        rx_mode     = RX_OPEN;
  int              rx_left     = 0;

  pid_step_with_output_clamp DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 60);
    end
    rx_left--;
    if (rx_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default:   m_axis_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      board.predict_drive(pid_op_e'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16],
                          s_axis_tdata[47:32]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_drive(m_axis_tdata, m_axis_tuser);
  end

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [14:0] limit);
    apb_write(REG_GAIN_P, kp);
    apb_write(REG_GAIN_I, ki);
    apb_write(REG_GAIN_D, kd);
    apb_write(REG_LIMIT, 32'(limit));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_beat(input pid_op_e op, input logic [15:0] setpoint,
                           input logic [15:0] measured, input logic [15:0] dt_ms);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        s_axis_tvalid <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 6))
          @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt_ms, measured, setpoint};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic send_random_beat();
    logic [15:0] sp;
    logic [15:0] ms;
    logic [15:0] dt;
    sp = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       ms = 16'($urandom);
      1:       ms = sp;
      default: ms = sp - 16'($urandom_range(0, 200)) + 16'd100;
    endcase
    case ($urandom_range(0, 9))
      0:       dt = 16'd0;
      1:       dt = 16'hFFFF;
      2:       dt = 16'($urandom);
      default: dt = 16'($urandom_range(1, 100));
    endcase
    send_beat(($urandom_range(0, 14) == 0) ? OP_CLEAR : OP_STEP, sp, ms, dt);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'($signed($urandom) >>> $urandom_range(4, 28));
    endcase
  endfunction

  function automatic logic [14:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'd1;
      3:       return 15'($urandom_range(2, 500));
      default: return 15'($urandom);
    endcase
  endfunction

  initial begin
    bit neg_side;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at their reset values
    send_beat(OP_STEP, 16'h7FFF, 16'h8000, 16'd10);
    send_beat(OP_STEP, 16'h0010, 16'h0000, 16'd0);
    wait_idle();

    load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 15'd1000);
    send_beat(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_STEP, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_beat(OP_STEP, 16'h8000, 16'h7FFF, 16'h0000);
    send_beat(OP_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_CLEAR, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_beat(OP_STEP, 16'd100, 16'd90, 16'd20);
    send_beat(OP_STEP, 16'd100, 16'd95, 16'd1);
    send_beat(OP_STEP, 16'hFFFB, 16'd5, 16'd20);
    send_beat(OP_STEP, 16'd1, 16'd0, 16'hFFFF);
    wait_idle();

    load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 15'h7FFF);
    send_beat(OP_STEP, 16'h7FFF, 16'h8000, 16'd1);
    send_beat(OP_STEP, 16'h8000, 16'h7FFF, 16'd1);
    send_beat(OP_STEP, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_beat(OP_STEP, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // zero limit
    load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 15'd0);
    send_beat(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_STEP, 16'd0, 16'd0, 16'd5);
    send_beat(OP_STEP, 16'd1, 16'd0, 16'd5);
    wait_idle();

    // drive the integral into saturation; gain_p offsets the integral term there
    load_gains(32'hFFDF_3B44, 32'h0000_0001, 32'h0000_0040, 15'h7FFF);
    neg_side    = 1'($urandom_range(0, 1));
    sender_gaps = 1'b0;
    rx_free     = 1'b1;
    send_beat(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    repeat (32790)
      send_beat(OP_STEP, neg_side ? 16'h8000 : 16'h7FFF, neg_side ? 16'h7FFF : 16'h8000,
                16'hFFFF);
    sender_gaps = 1'b1;
    rx_free     = 1'b0;
    repeat (20)
      send_beat(OP_STEP, neg_side ? 16'h7FFF : 16'h8000, neg_side ? 16'h8000 : 16'h7FFF,
                16'($urandom));
    wait_idle();

    for (int phase = 0; phase < 11; phase++) begin
      load_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit());
      repeat (50) send_random_beat();
      wait_idle();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("FAILED: results differ");
    $finish;
  end
endmodule
